FILE: hdl/bitmap_run_allocator_core_defines.svh
// ----------------------------------------------------------------------------
// bitmap run allocator assertion macros
// shared assertion wrappers, clocked on clk and held off during rst_n
// ----------------------------------------------------------------------------
`ifndef BITMAP_RUN_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_RUN_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication
`define BRA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/bra_pkg.sv
// ----------------------------------------------------------------------------
// bra_pkg
// sizes and command codes of the bitmap run allocator
// ----------------------------------------------------------------------------
`default_nettype none

package bra_pkg;

  localparam int MAX_BYTES = 512;
  localparam int ADDR_W    = $clog2(MAX_BYTES);
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int BIT_W     = ADDR_W + 3;
  localparam int RUN_W     = BIT_W + 1;
  localparam int CFG_W     = 10;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_TEST  = 2'd1;
  localparam logic [1:0] FUNC_FIND  = 2'd2;
  localparam logic [1:0] FUNC_WRITE = 2'd3;

endpackage

`default_nettype wire

FILE: hdl/bra_ram.sv
// ----------------------------------------------------------------------------
// bra_ram
// generic simple dual-port ram, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module bra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/bitmap_run_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_run_allocator_core
// allocation bitmap in a byte-wide ram with clear, test, write and first-fit
// search for a run of free bits
// ----------------------------------------------------------------------------
// After reset the block sweeps all 512 bytes of the bitmap ram to zero, one
// byte per cycle, and takes no request until the sweep is done; cfg writes are
// taken throughout. Requests are handled one at a time through the single ram
// read port: test and write go through read, use or write back, and result;
// clear zeroes the bytes in use and then gives its result, and find reads one
// byte per cycle up to the end of the run, or through all the bytes in use
// when no run fits, and then gives its result. The next request is taken
// while a result waits on the output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bitmap_run_allocator_core_defines.svh"

module bitmap_run_allocator_core
  import bra_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_func,
  input  wire logic [11:0]      in_bit_index,
  input  wire logic [12:0]      in_run_length,
  input  wire logic             in_bit_value,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic                  out_found,
  output logic      [11:0]      out_run_start,
  output logic                  out_bit_is_set,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data
);

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_TEST, ST_WMOD, ST_CLEAR, ST_FIND, ST_DONE
  } state_t;

  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   bytes_in_use_r, bytes_in_use_nxt;
  logic [CNT_W-1:0]   used;
  logic [BIT_W-1:0]   pos_r, pos_nxt;
  logic [RUN_W-1:0]   want_r, want_nxt;
  logic               val_r, val_nxt;
  logic [CNT_W-1:0]   addr_r, addr_nxt;
  logic [CNT_W-1:0]   end_r, end_nxt;
  logic               pend_r, pend_nxt;
  logic [ADDR_W-1:0]  pend_addr_r, pend_addr_nxt;
  logic [RUN_W-1:0]   run_cnt_r, run_cnt_nxt;
  logic               res_found_r, res_found_nxt;
  logic [BIT_W-1:0]   res_start_r, res_start_nxt;
  logic               res_isset_r, res_isset_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [BIT_W-1:0]   out_start_r, out_start_nxt;
  logic               out_isset_r, out_isset_nxt;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [7:0]         ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [7:0]         ram_rdata;
  logic [7:0]         bit_mask;

  logic [RUN_W-1:0]   scan_cnt;
  logic               scan_hit;
  logic [2:0]         scan_k;
  logic [RUN_W-1:0]   scan_pos;
  logic [RUN_W-1:0]   scan_start;

  bra_ram #(
    .WIDTH (8),
    .DEPTH (MAX_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign used = (bytes_in_use_r > CFG_W'(MAX_BYTES)) ? CNT_W'(MAX_BYTES)
                                                      : CNT_W'(bytes_in_use_r);
  assign bit_mask = 8'(1) << pos_r[2:0];

  // free-run count over the byte just read, lsb first
  always_comb begin
    scan_cnt = run_cnt_r;
    scan_hit = 1'b0;
    scan_k   = 3'd0;
    for (int k = 0; k < 8; k++) begin
      if (!scan_hit) begin
        if (!ram_rdata[k]) begin
          scan_cnt = scan_cnt + RUN_W'(1);
          if (scan_cnt == want_r) begin
            scan_hit = 1'b1;
            scan_k   = 3'(k);
          end
        end else begin
          scan_cnt = '0;
        end
      end
    end
    scan_pos   = {1'b0, pend_addr_r, scan_k};
    scan_start = scan_pos + RUN_W'(1) - want_r;
  end

  always_comb begin
    state_nxt        = state_r;
    bytes_in_use_nxt = cfg_wr_en ? cfg_wr_data : bytes_in_use_r;
    pos_nxt          = pos_r;
    want_nxt         = want_r;
    val_nxt          = val_r;
    addr_nxt         = addr_r;
    end_nxt          = end_r;
    pend_nxt         = pend_r;
    pend_addr_nxt    = pend_addr_r;
    run_cnt_nxt      = run_cnt_r;
    res_found_nxt    = res_found_r;
    res_start_nxt    = res_start_r;
    res_isset_nxt    = res_isset_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_found_nxt    = out_found_r;
    out_start_nxt    = out_start_r;
    out_isset_nxt    = out_isset_r;
    in_ready         = 1'b0;
    ram_we           = 1'b0;
    ram_waddr        = addr_r[ADDR_W-1:0];
    ram_wdata        = 8'h00;
    ram_raddr        = in_bit_index[BIT_W-1:3];

    case (state_r)
      ST_INIT: begin
        if (addr_r < end_r) begin
          ram_we   = 1'b1;
          addr_nxt = addr_r + CNT_W'(1);
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          pos_nxt       = in_bit_index;
          want_nxt      = in_run_length;
          val_nxt       = in_bit_value;
          res_found_nxt = 1'b0;
          res_start_nxt = '0;
          res_isset_nxt = 1'b0;
          addr_nxt      = '0;
          end_nxt       = used;
          pend_nxt      = 1'b0;
          run_cnt_nxt   = '0;
          case (in_func)
            FUNC_CLEAR: state_nxt = ST_CLEAR;
            FUNC_TEST:  state_nxt = ST_TEST;
            FUNC_FIND: begin
              if (in_run_length == '0 || used == '0) begin
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_FIND;
              end
            end
            FUNC_WRITE: state_nxt = ST_WMOD;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_TEST: begin
        res_isset_nxt = ram_rdata[pos_r[2:0]];
        state_nxt     = ST_DONE;
      end
      ST_WMOD: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r[BIT_W-1:3];
        ram_wdata = val_r ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
        state_nxt = ST_DONE;
      end
      ST_CLEAR: begin
        if (addr_r < end_r) begin
          ram_we   = 1'b1;
          addr_nxt = addr_r + CNT_W'(1);
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_FIND: begin
        ram_raddr = addr_r[ADDR_W-1:0];
        if (addr_r < end_r) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = addr_r[ADDR_W-1:0];
          addr_nxt      = addr_r + CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          run_cnt_nxt = scan_cnt;
          if (scan_hit) begin
            res_found_nxt = 1'b1;
            res_start_nxt = scan_start[BIT_W-1:0];
            state_nxt     = ST_DONE;
          end
        end else if (addr_r >= end_r) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_start_nxt = res_start_r;
          out_isset_nxt = res_isset_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_INIT;
      bytes_in_use_r <= CFG_W'(MAX_BYTES);
      addr_r         <= '0;
      end_r          <= CNT_W'(MAX_BYTES);
      pend_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      bytes_in_use_r <= bytes_in_use_nxt;
      addr_r         <= addr_nxt;
      end_r          <= end_nxt;
      pend_r         <= pend_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    pos_r       <= pos_nxt;
    want_r      <= want_nxt;
    val_r       <= val_nxt;
    pend_addr_r <= pend_addr_nxt;
    run_cnt_r   <= run_cnt_nxt;
    res_found_r <= res_found_nxt;
    res_start_r <= res_start_nxt;
    res_isset_r <= res_isset_nxt;
    out_found_r <= out_found_nxt;
    out_start_r <= out_start_nxt;
    out_isset_r <= out_isset_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_run_start  = out_start_r;
  assign out_bit_is_set = out_isset_r;

  `BRA_ASSERT_IMPL(a_ram_we_state, ram_we,
    (state_r == ST_INIT) || (state_r == ST_CLEAR) || (state_r == ST_WMOD),
    "bitmap ram written outside clear or write-back")
  `BRA_ASSERT_NEXT(a_one_request, in_valid && in_ready, !in_ready,
    "second request taken while one is in progress")
  `BRA_ASSERT_IMPL(a_found_excl, out_valid && out_found, !out_bit_is_set,
    "find result also reports a tested bit")
  `BRA_ASSERT_IMPL(a_scan_bound, state_r == ST_FIND, addr_r <= end_r,
    "search address past the bytes in use")

endmodule

`default_nettype wire
